>>> design/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the pixel format to RGBA8 converter
// Transaction payloads, configuration record, pipeline records, format codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

	// default palette depth
	localparam int PALETTE_DEPTH_DEF = 256;
	// palette_size / index comparison width (holds 0..511)
	localparam int PAL_SIZE_W = 9;

	// input operation codes
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	// source_format codes
	localparam logic [2:0] FMT_RGB8       = 3'd0;
	localparam logic [2:0] FMT_RGB16      = 3'd1;
	localparam logic [2:0] FMT_RGBA8      = 3'd2;
	localparam logic [2:0] FMT_RGBA16     = 3'd3;
	localparam logic [2:0] FMT_LUM8       = 3'd4;
	localparam logic [2:0] FMT_LUM_ALPHA8 = 3'd5;
	localparam logic [2:0] FMT_INDEX8     = 3'd6;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_RGB      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE  = 2'd3;
	localparam int CFG_DATA_W = 32;

	// weighted luminance: sum = 2r+3g+b+bias, divided by 6 (8-bit) or 1542 (16-bit)
	localparam int LUM_SUM_W = 19;
	localparam logic [LUM_SUM_W-1:0] LUM_BIAS8  = 19'd3;
	localparam logic [LUM_SUM_W-1:0] LUM_BIAS16 = 19'd771;   // 3 * 257
	// reciprocals: x/6 = (x*2731)>>14 for x < 8192,
	// x/1542 = (x*348166)>>29 for x < 506482
	localparam logic [LUM_SUM_W-1:0] RECIP8   = 19'd2731;
	localparam int                   SHIFT8   = 14;
	localparam logic [LUM_SUM_W-1:0] RECIP16  = 19'd348166;
	localparam int                   SHIFT16  = 29;
	localparam int                   PROD_W   = 2 * LUM_SUM_W;

	localparam logic [31:0] OPAQUE_BLACK_RGB = 32'h00FF_FFFF;

	typedef struct packed {
		logic        operation;
		logic [7:0]  palette_index;
		logic [31:0] palette_word;
		logic [15:0] chan_a;
		logic [15:0] chan_b;
		logic [15:0] chan_c;
		logic [15:0] chan_d;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] rgba_out;
		logic        last_out;
	} out_item_t;

	typedef struct packed {
		logic [2:0]            source_format;
		logic                  alpha_mode;
		logic [23:0]           fill_rgb;
		logic [PAL_SIZE_W-1:0] palette_size;
	} cfg_t;

	// stage 1: pixel fields alongside the palette read
	typedef struct packed {
		logic [15:0] chan_a;
		logic [15:0] chan_b;
		logic [15:0] chan_c;
		logic [15:0] chan_d;
		logic        last;
		logic        in_pal;
	} s1_t;

	// stage 2: base word plus pending luminance division
	typedef struct packed {
		logic [31:0]          base_word;
		logic [LUM_SUM_W-1:0] lum_sum;
		logic                 is16;
		logic                 use_lum;
		logic                 last;
	} s2_t;

endpackage

`default_nettype wire

>>> design/pfr_palette_ram.sv
// ----------------------------------------------------------------------------
// pfr_palette_ram: palette store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_palette_ram #(
	parameter int DEPTH  = pfr_pkg::PALETTE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [31:0]       wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [31:0]       rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/pfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfr_cfg_regs: configuration register file
// Decodes the write channel into the four control registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [pfr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [pfr_pkg::CFG_DATA_W-1:0]    wr_data,
	output pfr_pkg::cfg_t                          cfg
);

	import pfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SOURCE_FORMAT: cfg_q.source_format <= wr_data[2:0];
				REG_ALPHA_MODE:    cfg_q.alpha_mode    <= wr_data[0];
				REG_FILL_RGB:      cfg_q.fill_rgb      <= wr_data[23:0];
				REG_PALETTE_SIZE:  cfg_q.palette_size  <= wr_data[PAL_SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/pfr_format_stage.sv
// ----------------------------------------------------------------------------
// pfr_format_stage: format decode
// Builds the packed word for direct formats and the luminance sum for the
// alpha path; registers the result as stage 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_format_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  pfr_pkg::cfg_t      cfg,
	input  wire logic          valid_s1,
	input  pfr_pkg::s1_t       s1,
	input  wire logic [31:0]   entry,
	output logic               valid_s2,
	output pfr_pkg::s2_t       s2
);

	import pfr_pkg::*;

	s2_t  nxt;
	logic [15:0] lr, lg, lb;
	logic [LUM_SUM_W-1:0] bias;
	logic valid_s2_q;
	s2_t  s2_q;

	always_comb begin
		nxt           = '0;
		nxt.last      = s1.last;
		lr            = {8'h00, s1.chan_a[7:0]};
		lg            = {8'h00, s1.chan_b[7:0]};
		lb            = {8'h00, s1.chan_c[7:0]};
		bias          = LUM_BIAS8;
		if (!cfg.alpha_mode) begin
			case (cfg.source_format)
				FMT_RGB8:       nxt.base_word = {8'hFF, s1.chan_c[7:0], s1.chan_b[7:0],
					s1.chan_a[7:0]};
				FMT_RGB16:      nxt.base_word = {8'hFF, s1.chan_c[15:8], s1.chan_b[15:8],
					s1.chan_a[15:8]};
				FMT_RGBA8:      nxt.base_word = {s1.chan_d[7:0], s1.chan_c[7:0],
					s1.chan_b[7:0], s1.chan_a[7:0]};
				FMT_RGBA16:     nxt.base_word = {s1.chan_d[15:8], s1.chan_c[15:8],
					s1.chan_b[15:8], s1.chan_a[15:8]};
				FMT_LUM8:       nxt.base_word = {8'hFF, {3{s1.chan_a[7:0]}}};
				FMT_LUM_ALPHA8: nxt.base_word = {s1.chan_b[7:0], {3{s1.chan_a[7:0]}}};
				FMT_INDEX8:     nxt.base_word = s1.in_pal ? entry : 32'h0;
				default:        nxt.base_word = 32'h0;
			endcase
		end else begin
			case (cfg.source_format) inside
				FMT_RGB8, FMT_RGBA8: begin
					nxt.base_word = {8'h00, cfg.fill_rgb};
					nxt.use_lum   = 1'b1;
				end
				FMT_RGB16, FMT_RGBA16: begin
					nxt.base_word = {8'h00, cfg.fill_rgb};
					nxt.use_lum   = 1'b1;
					nxt.is16      = 1'b1;
					lr            = s1.chan_a;
					lg            = s1.chan_b;
					lb            = s1.chan_c;
					bias          = LUM_BIAS16;
				end
				FMT_LUM8, FMT_LUM_ALPHA8: begin
					nxt.base_word = {s1.chan_a[7:0], cfg.fill_rgb};
				end
				FMT_INDEX8: begin
					if (s1.in_pal) begin
						nxt.base_word = {8'h00, cfg.fill_rgb};
						nxt.use_lum   = 1'b1;
						lr            = {8'h00, entry[7:0]};
						lg            = {8'h00, entry[15:8]};
						lb            = {8'h00, entry[23:16]};
					end else begin
						nxt.base_word = OPAQUE_BLACK_RGB;
					end
				end
				default: nxt.base_word = 32'h0;
			endcase
		end
		nxt.lum_sum = {2'b00, lr, 1'b0} + ({3'b000, lg} + {2'b00, lg, 1'b0})
			+ {3'b000, lb} + bias;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
		end else if (advance) begin
			valid_s2_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			s2_q <= nxt;
		end
	end

	assign valid_s2 = valid_s2_q;
	assign s2       = s2_q;

endmodule

`default_nettype wire

>>> design/pixel_format_to_rgba8_core.sv
// ----------------------------------------------------------------------------
// pixel_format_to_rgba8_core: source pixel to packed RGBA8 converter
// Top level: input handshake, palette RAM, decode stage, divider and output.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock unless the output stalls, palette
// writes and pixels alike, with no clearing pass after reset. A pixel passes
// three registers (palette RAM read, format decode, luminance divide and
// pack): the edge that accepts it loads the first, and each advance moves
// it on into the next register, up to the output. The pipeline keeps taking one
// pixel per clock as long as results are taken. The whole pipeline stalls
// together while a result waits at the output, so in_ready is low exactly
// while out_valid is high and out_ready is low. Palette writes give no result;
// they land in the RAM at acceptance, so a pixel right behind a write already
// sees the new entry through the single read port. Palette entries never
// written read as unknown. Configuration writes are taken every cycle
// (cfg_ready is always high) and must only happen while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_to_rgba8_core #(
	parameter int PALETTE_DEPTH = pfr_pkg::PALETTE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// pixel / palette transactions
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  pfr_pkg::in_item_t                   in_data,
	// converted pixels
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output pfr_pkg::out_item_t                  out_data,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	import pfr_pkg::*;

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);

	cfg_t cfg;
	logic advance;
	logic accept;
	logic accept_pixel;
	logic idx_in_depth;
	logic [PAL_SIZE_W-1:0] idx_ext;
	logic [PAL_SIZE_W-1:0] pal_idx_ext;

	logic valid_s1;
	s1_t  s1;
	logic [31:0] entry;

	logic valid_s2;
	s2_t  s2;

	logic [PROD_W-1:0] prod;
	logic [7:0]        lum;
	logic [31:0]       rgba_nxt;

	logic        out_valid_q;
	out_item_t   out_q;

	// whole pipeline moves when the output slot is free or being drained
	assign advance      = !out_valid_q || out_ready;
	assign in_ready     = advance;
	assign accept       = in_valid && advance;
	assign accept_pixel = accept && (in_data.operation == OP_PIXEL);
	assign cfg_ready    = 1'b1;

	pfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// palette write address check; writes beyond the depth are dropped
	assign pal_idx_ext  = {1'b0, in_data.palette_index};
	assign idx_in_depth = pal_idx_ext < PAL_SIZE_W'(PALETTE_DEPTH);
	// pixel index for index8 lookups
	assign idx_ext      = {1'b0, in_data.chan_a[7:0]};

	pfr_palette_ram #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && (in_data.operation == OP_PAL_WRITE) && idx_in_depth),
		.waddr (in_data.palette_index[ADDR_W-1:0]),
		.wdata (in_data.palette_word),
		.re    (accept_pixel),
		.raddr (in_data.chan_a[ADDR_W-1:0]),
		.rdata (entry)
	);

	// stage 1: pixel fields wait beside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_pixel) begin
			s1.chan_a <= in_data.chan_a;
			s1.chan_b <= in_data.chan_b;
			s1.chan_c <= in_data.chan_c;
			s1.chan_d <= in_data.chan_d;
			s1.last   <= in_data.last_in;
			s1.in_pal <= (idx_ext < cfg.palette_size)
				&& (idx_ext < PAL_SIZE_W'(PALETTE_DEPTH));
		end
	end

	// stage 2 decode
	pfr_format_stage u_fmt (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.s1       (s1),
		.entry    (entry),
		.valid_s2 (valid_s2),
		.s2       (s2)
	);

	// luminance divide by reciprocal multiply; one shared multiplier
	assign prod = PROD_W'(s2.lum_sum) * PROD_W'(s2.is16 ? RECIP16 : RECIP8);
	assign lum  = s2.is16 ? prod[SHIFT16 +: 8] : prod[SHIFT8 +: 8];

	assign rgba_nxt = s2.use_lum ? (s2.base_word | {lum, 24'h000000}) : s2.base_word;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			out_q.rgba_out <= rgba_nxt;
			out_q.last_out <= s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> design/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker: port-level checks for the RGBA8 converter
// Watches handshakes and pipeline timing; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input pfr_pkg::in_item_t       in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input pfr_pkg::out_item_t      out_data
);

	import pfr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// a blocked output blocks the input side
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output is stalled");

	// empty output slot never refuses input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	// an accepted pixel reaches the output when the sink keeps up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.operation == OP_PIXEL))
		##1 out_ready ##1 out_ready |=> out_valid)
		else $error("pixel result missing after pipeline latency");

endmodule

bind pixel_format_to_rgba8_core pfr_checker u_pfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_format_to_rgba8_core
// Sends palette writes and pixels over the input channel and keeps its own
// copy of the registers and palette. From these it predicts the packed RGBA8
// word of every pixel and checks the results in order, with random stalls on
// both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pfr_pkg::*;

	localparam int         PAL_DEPTH       = 256;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         DRAIN_CYCLES    = 8;     // pipeline is 3 deep, leave margin
	localparam int         ITEMS_PER_PHASE = 370;
	localparam int         LUM16_SCALE     = 257;   // 16-bit sums are scaled by 257
	localparam logic [2:0] FMT_UNUSED      = 3'd7;  // no format behind this code
	localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// behavioral copy of the block's registers and palette RAM, updated at
	// the edge where the matching transaction is accepted
	cfg_t        cur_cfg;
	logic [31:0] pal_mem [PAL_DEPTH];

	// converted pixels still owed by the block, oldest first
	out_item_t pending_pixels [$];
	out_item_t next_want;

	// idle rates in percent of cycles, changed per test phase
	int send_idle_pct;
	int recv_stall_pct;

	int mismatch_count;
	int cycle_count;

	pixel_format_to_rgba8_core #(
		.PALETTE_DEPTH(PAL_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker: every accepted output transaction is matched against
	// the oldest pending prediction, field by field
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result rgba_out %h last_out %b", $time,
					out_data.rgba_out, out_data.last_out);
				mismatch_count++;
			end else begin
				next_want = pending_pixels.pop_front();
				if (out_data.rgba_out !== next_want.rgba_out) begin
					$display("%0t: rgba_out expected %h actual %h", $time,
						next_want.rgba_out, out_data.rgba_out);
					mismatch_count++;
				end
				if (out_data.last_out !== next_want.last_out) begin
					$display("%0t: last_out expected %b actual %b", $time,
						next_want.last_out, out_data.last_out);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// rounded weighted luminance, 8-bit components
	function automatic logic [7:0] luma8(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned sum;
		sum = 2 * int'(r) + 3 * int'(g) + int'(b) + 3;
		return 8'(sum / 6);
	endfunction

	// same weighting on full 16-bit components, rounded back to a byte
	function automatic logic [7:0] luma16(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b);
		int unsigned sum;
		sum = 2 * int'(r) + 3 * int'(g) + int'(b) + 3 * LUM16_SCALE;
		return 8'(sum / (6 * LUM16_SCALE));
	endfunction

	function automatic out_item_t convert_pixel(input in_item_t px);
		out_item_t   res;
		logic [7:0]  idx;
		logic        in_pal;
		logic [31:0] entry;
		logic [31:0] word;
		idx    = px.chan_a[7:0];
		in_pal = ({1'b0, idx} < cur_cfg.palette_size) && (int'(idx) < PAL_DEPTH);
		entry  = in_pal ? pal_mem[idx] : 32'h0;
		if (!cur_cfg.alpha_mode) begin
			case (cur_cfg.source_format)
				FMT_RGB8: begin
					word = {ALPHA_OPAQUE, px.chan_c[7:0], px.chan_b[7:0], px.chan_a[7:0]};
				end
				FMT_RGB16: begin
					word = {ALPHA_OPAQUE, px.chan_c[15:8], px.chan_b[15:8], px.chan_a[15:8]};
				end
				FMT_RGBA8: begin
					word = {px.chan_d[7:0], px.chan_c[7:0], px.chan_b[7:0], px.chan_a[7:0]};
				end
				FMT_RGBA16: begin
					word = {px.chan_d[15:8], px.chan_c[15:8], px.chan_b[15:8],
						px.chan_a[15:8]};
				end
				FMT_LUM8:       word = {ALPHA_OPAQUE, {3{px.chan_a[7:0]}}};
				FMT_LUM_ALPHA8: word = {px.chan_b[7:0], {3{px.chan_a[7:0]}}};
				FMT_INDEX8:     word = entry;   // already zero when out of range
				default:        word = 32'h0;
			endcase
		end else begin
			// fixed colour, alpha carries the luminance
			case (cur_cfg.source_format)
				FMT_RGB8, FMT_RGBA8: begin
					word = {luma8(px.chan_a[7:0], px.chan_b[7:0], px.chan_c[7:0]),
						cur_cfg.fill_rgb};
				end
				FMT_RGB16, FMT_RGBA16: begin
					word = {luma16(px.chan_a, px.chan_b, px.chan_c), cur_cfg.fill_rgb};
				end
				FMT_LUM8, FMT_LUM_ALPHA8: begin
					word = {px.chan_a[7:0], cur_cfg.fill_rgb};
				end
				FMT_INDEX8: begin
					if (in_pal)
						word = {luma8(entry[7:0], entry[15:8], entry[23:16]), cur_cfg.fill_rgb};
					else
						word = OPAQUE_BLACK_RGB;
				end
				default: word = 32'h0;
			endcase
		end
		res.rgba_out = word;
		res.last_out = px.last_in;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// item builders; fields the operation does not use carry random junk
	// ------------------------------------------------------------------

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic in_item_t pixel_item(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input logic last);
		in_item_t it;
		it.operation     = OP_PIXEL;
		it.palette_index = 8'($urandom_range(255));
		it.palette_word  = $urandom;
		it.chan_a        = a;
		it.chan_b        = b;
		it.chan_c        = c;
		it.chan_d        = d;
		it.last_in       = last;
		return it;
	endfunction

	function automatic in_item_t palette_item(input logic [7:0] idx, input logic [31:0] word);
		in_item_t it;
		it.operation     = OP_PAL_WRITE;
		it.palette_index = idx;
		it.palette_word  = word;
		it.chan_a        = rand_chan();
		it.chan_b        = rand_chan();
		it.chan_c        = rand_chan();
		it.chan_d        = rand_chan();
		it.last_in       = 1'($urandom_range(1));
		return it;
	endfunction

	// random pixel; with a nonzero palette size most indexes land inside it
	function automatic in_item_t random_pixel(input logic [8:0] psize, input logic image_end);
		in_item_t it;
		it = pixel_item(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
			image_end || ($urandom_range(15) == 0));
		if (psize != 0 && $urandom_range(3) != 0)
			it.chan_a[7:0] = 8'($urandom_range((psize > 256) ? 255 : int'(psize) - 1));
		return it;
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	// Entered and left at a falling edge. Valid stays high on return so a
	// following call can present the next transaction back to back; a gap
	// drops valid first and raises it again only once a random idle draw fails.
	task automatic send_item(input in_item_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// palette writes land in the RAM at acceptance, so the very next
		// pixel already sees them
		if (item.operation == OP_PAL_WRITE)
			pal_mem[item.palette_index] = item.palette_word;
		else
			pending_pixels.push_back(convert_pixel(item));
		@(negedge clk);
	endtask

	// stop sending and let every pixel in flight come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SOURCE_FORMAT: cur_cfg.source_format = data[2:0];
			REG_ALPHA_MODE:    cur_cfg.alpha_mode    = data[0];
			REG_FILL_RGB:      cur_cfg.fill_rgb      = data[23:0];
			REG_PALETTE_SIZE:  cur_cfg.palette_size  = data[PAL_SIZE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// register value with random bits above its width
	function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
		logic [31:0] mask;
		mask = (32'h1 << width) - 32'h1;
		return ($urandom & ~mask) | (value & mask);
	endfunction

	// all four registers, written only once the block has gone quiet
	task automatic set_config(input logic [2:0] fmt, input logic mode,
			input logic [23:0] fill, input logic [8:0] psize);
		wait_drained();
		write_reg(REG_SOURCE_FORMAT, with_junk(32'(fmt), 3));
		write_reg(REG_ALPHA_MODE, with_junk(32'(mode), 1));
		write_reg(REG_FILL_RGB, with_junk(32'(fill), 24));
		write_reg(REG_PALETTE_SIZE, with_junk(32'(psize), PAL_SIZE_W));
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// a few entries, including the top one; palette size stays 0 for now
	task automatic test_palette_load();
		send_item(palette_item(8'd0, 32'h0000_0000));
		send_item(palette_item(8'd1, 32'hFFFF_FFFF));
		send_item(palette_item(8'd2, 32'hA5C3_5A3C));
		send_item(palette_item(8'd255, 32'h1234_5678));
	endtask

	// each direct format in plain mode, with extreme channel values
	task automatic test_plain_formats();
		set_config(FMT_RGB8, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'hFF00, 16'h00FF, 16'h1234, 16'hFFFF, 1'b1));
		set_config(FMT_RGB16, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'hFFFF, 16'h0000, 16'h80FF, 16'h0000, 1'b0));
		set_config(FMT_RGBA8, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'h00FF, 16'hFF00, 16'h00A5, 16'h00FF, 1'b1));
		set_config(FMT_RGBA16, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		set_config(FMT_LUM8, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'hFF00, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
		set_config(FMT_LUM_ALPHA8, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'h00FF, 16'h0080, 16'hFFFF, 16'hFFFF, 1'b0));
	endtask

	// indexes on both sides of the palette size; entry 255 is written but
	// still out of range
	task automatic test_index_range();
		set_config(FMT_INDEX8, 1'b0, 24'h0, 9'd3);
		send_item(pixel_item(16'hFF00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_item(pixel_item(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_item(pixel_item(16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_item(pixel_item(16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_item(pixel_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1));
	endtask

	// luminance into alpha: full and empty sums, 16-bit rounding, luminance
	// byte taken directly, palette entry in and out of range
	task automatic test_alpha_mode();
		set_config(FMT_RGB8, 1'b1, 24'hFFFFFF, 9'd3);
		send_item(pixel_item(16'h00FF, 16'h00FF, 16'h00FF, 16'h0000, 1'b1));
		send_item(pixel_item(16'hFF00, 16'hFF00, 16'hFF00, 16'hFFFF, 1'b0));
		set_config(FMT_RGB16, 1'b1, 24'h000000, 9'd3);
		send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
		send_item(pixel_item(16'h0101, 16'h0302, 16'h0000, 16'h0000, 1'b0));
		set_config(FMT_LUM_ALPHA8, 1'b1, 24'h5AA5C3, 9'd3);
		send_item(pixel_item(16'h00FF, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		set_config(FMT_INDEX8, 1'b1, 24'h123456, 9'd3);
		send_item(pixel_item(16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_item(pixel_item(16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b1));
	endtask

	// format code 7 gives zero in both modes
	task automatic test_unused_format();
		set_config(FMT_UNUSED, 1'b0, 24'hFFFFFF, 9'd3);
		send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		set_config(FMT_UNUSED, 1'b1, 24'hFFFFFF, 9'd3);
		send_item(pixel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
	endtask

	// Write every entry, then read every eighth index at full palette size.
	// From here on every index is readable whatever the size.
	task automatic test_palette_fill();
		for (int i = 0; i < PAL_DEPTH; i++)
			send_item(palette_item(8'(i), $urandom));
		set_config(FMT_INDEX8, 1'b0, 24'h0, 9'd256);
		for (int i = 0; i < PAL_DEPTH; i += 8)
			send_item(pixel_item({8'($urandom_range(255)), 8'(i)}, rand_chan(), rand_chan(),
				rand_chan(), 1'(i == PAL_DEPTH - 8)));
	endtask

	// Images of random length under a random configuration each, with
	// palette rewrites mixed in between the pixels.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int         sent;
		int         seg_len;
		logic [2:0] fmt;
		logic [23:0] fill;
		logic [8:0] psize;
		in_item_t   it;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < ITEMS_PER_PHASE) begin
			fmt = ($urandom_range(3) == 0) ? FMT_INDEX8 : 3'($urandom_range(7));
			case ($urandom_range(2))
				0:       fill = 24'h000000;
				1:       fill = 24'hFFFFFF;
				default: fill = 24'($urandom);
			endcase
			// sizes beyond the depth are legal register values too
			case ($urandom_range(5))
				0:       psize = 9'd0;
				1:       psize = 9'd1;
				2:       psize = 9'd256;
				3:       psize = 9'd511;
				4:       psize = 9'($urandom_range(256));
				default: psize = 9'($urandom_range(511, 257));
			endcase
			set_config(fmt, 1'($urandom_range(1)), fill, psize);
			seg_len = $urandom_range(20, 60);
			for (int k = 0; k < seg_len; k++) begin
				if ($urandom_range(99) < 12)
					it = palette_item(8'($urandom_range(255)), $urandom);
				else
					it = random_pixel(psize, k == seg_len - 1);
				send_item(it);
			end
			sent += seg_len;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cur_cfg        = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		send_idle_pct  = 29;
		recv_stall_pct = 76;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_palette_load();
		test_plain_formats();
		test_index_range();
		test_alpha_mode();
		test_unused_format();
		test_palette_fill();
		test_random_traffic(29, 76);
		test_random_traffic(76, 29);
		test_random_traffic(0, 0);

		wait_drained();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
